### hw/rtl/bounded_disorder_reorder_buffer_assert.svh
// Assertion macros shared by the reorder buffer RTL.
`ifndef BOUNDED_DISORDER_REORDER_BUFFER_ASSERT_SVH
`define BOUNDED_DISORDER_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BDRB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BDRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bdrb_pkg.sv
package bdrb_pkg;

   localparam int DEPTH    = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CONTIG_W = 16;
   localparam int POS_W    = 31;
   localparam int CARGO_W  = 8;
   localparam int SPAN_W   = 20;
   localparam int ENTRY_W  = CONTIG_W + POS_W + CARGO_W;
   localparam int DATA_W   = ((ENTRY_W + 7) / 8) * 8;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // field order gives the sort key: contig, then position, then cargo
   typedef struct packed {
      logic [CONTIG_W-1:0] contig;
      logic [POS_W-1:0]    position;
      logic [CARGO_W-1:0]  cargo;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } slot_ctrl_type;

endpackage

### hw/rtl/bdrb_cell.sv
module bdrb_cell (
   input  logic                    clock,
   input  bdrb_pkg::slot_ctrl_type ctrl,
   input  logic                    occupied,
   input  bdrb_pkg::entry_type     new_entry,
   input  bdrb_pkg::entry_type     left_entry,
   input  logic                    left_le,
   input  bdrb_pkg::entry_type     right_entry,
   output bdrb_pkg::entry_type     entry,
   output logic                    le
);
   import bdrb_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // le: this slot holds a key not above the new one, so it stays put
   assign le    = occupied && (entry_ff <= new_entry);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.insert && !le) begin
         entry_in = left_le ? new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hw/rtl/bounded_disorder_reorder_buffer.sv
// Sorted reorder buffer for a nearly ordered stream of (contig, position, cargo) items, kept
// in a row of DEPTH slots that shift together: an insert moves every slot above the new key
// one place up, and a release moves the whole row one place down. An insert item passes
// through accept, insert and release check steps; the release check step carries the first
// release, if any, and each further one. A full buffer adds a step that pops the head before
// the insert, and that forced head is released first. Each result leaves through a one-item
// output register, and a result that waits there unaccepted stalls the next release. A flush
// item releases every held entry in turn, from the head. Items are accepted only between
// operations, while a previous result may still wait at the output. The user must write
// max_span through csr_we/csr_wdata only while the block is idle; the block itself does not
// enforce this.
`include "bounded_disorder_reorder_buffer_assert.svh"

module bounded_disorder_reorder_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bdrb_pkg::SPAN_W-1:0]   csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // contig_id, position, cargo
   input  logic [bdrb_pkg::DATA_W-1:0]   req_tdata,
   // kind
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_contig, out_position, out_cargo
   output logic [bdrb_pkg::DATA_W-1:0]   rsp_tdata,
   // forced
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);
   import bdrb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FORCE = 5'b00010,
      S_INS   = 5'b00100,
      S_REL   = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SPAN_W-1:0] span_ff;
   logic              force_pend_ff, force_pend_in;
   entry_type         item_ff, item_in;
   entry_type         tail_ff, tail_in;
   entry_type         force_ff, force_in;

   logic              rsp_valid_ff;
   entry_type         rsp_entry_ff;
   logic              rsp_forced_ff;
   logic              rsp_last_ff;

   slot_ctrl_type     ctrl;
   entry_type         slot_entry [DEPTH];
   logic [DEPTH-1:0]  slot_le;
   logic [DEPTH-1:0]  slot_occ;

   logic              out_free;
   logic              emit;
   entry_type         emit_entry;
   logic              emit_forced;
   logic              emit_last;
   logic              far_now;
   logic              far_next;
   logic              ins_at_end;
   entry_type         req_entry;

   function automatic logic is_far(entry_type head, entry_type tail,
                                   logic [SPAN_W-1:0] span);
      logic [POS_W:0] diff;
      diff = {1'b0, tail.position} - {1'b0, head.position};
      return (head.contig != tail.contig) || (diff > (POS_W + 1)'(span));
   endfunction

   assign req_entry.contig   = req_tdata[CONTIG_W-1:0];
   assign req_entry.position = req_tdata[CONTIG_W+POS_W-1:CONTIG_W];
   assign req_entry.cargo    = req_tdata[ENTRY_W-1:CONTIG_W+POS_W];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_slot
         assign slot_occ[gi] = count_ff > CNT_W'(gi);
         bdrb_cell u_slot (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (slot_occ[gi]),
            .new_entry   (item_ff),
            .left_entry  ((gi == 0) ? item_ff : slot_entry[(gi == 0) ? 0 : gi - 1]),
            .left_le     ((gi == 0) ? 1'b1 : slot_le[(gi == 0) ? 0 : gi - 1]),
            .right_entry (slot_entry[(gi == DEPTH - 1) ? gi : gi + 1]),
            .entry       (slot_entry[gi]),
            .le          (slot_le[gi])
         );
      end
   endgenerate

   assign ins_at_end = &(slot_le | ~slot_occ);
   assign far_now    = (count_ff > CNT_W'(1)) && is_far(slot_entry[0], tail_ff, span_ff);
   assign far_next   = (count_ff > CNT_W'(2)) && is_far(slot_entry[1], tail_ff, span_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      force_pend_in = force_pend_ff;
      item_in       = item_ff;
      tail_in       = tail_ff;
      force_in      = force_ff;
      ctrl          = '0;
      emit          = 1'b0;
      emit_entry    = slot_entry[0];
      emit_forced   = 1'b0;
      emit_last     = 1'b0;
      req_tready    = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in = req_entry;
               if (req_tuser == KIND_FLUSH) begin
                  state_in = S_FLUSH;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  state_in = S_FORCE;
               end else begin
                  state_in = S_INS;
               end
            end
         end
         S_FORCE: begin
            ctrl.pop      = 1'b1;
            force_in      = slot_entry[0];
            count_in      = count_ff - CNT_W'(1);
            force_pend_in = 1'b1;
            state_in      = S_INS;
         end
         S_INS: begin
            ctrl.insert = 1'b1;
            count_in    = count_ff + CNT_W'(1);
            if (ins_at_end) begin
               tail_in = item_ff;
            end
            state_in = S_REL;
         end
         S_REL: begin
            if (force_pend_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  emit_entry    = force_ff;
                  emit_forced   = 1'b1;
                  emit_last     = !far_now;
                  force_pend_in = 1'b0;
                  if (!far_now) begin
                     state_in = S_IDLE;
                  end
               end
            end else if (far_now) begin
               if (out_free) begin
                  ctrl.pop  = 1'b1;
                  emit      = 1'b1;
                  emit_last = !far_next;
                  count_in  = count_ff - CNT_W'(1);
                  if (!far_next) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               ctrl.pop  = 1'b1;
               emit      = 1'b1;
               emit_last = (count_ff == CNT_W'(1));
               count_in  = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         span_ff       <= '0;
         force_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         force_pend_ff <= force_pend_in;
         if (csr_we) begin
            span_ff <= csr_wdata;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      tail_ff  <= tail_in;
      force_ff <= force_in;
      if (emit) begin
         rsp_entry_ff  <= emit_entry;
         rsp_forced_ff <= emit_forced;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_entry_ff.cargo, rsp_entry_ff.position,
                                rsp_entry_ff.contig});
   assign rsp_tuser  = rsp_forced_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BDRB_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "held count above depth")
   `BDRB_ASSERT_SAME(a_pop_nonempty, ctrl.pop, count_ff != '0, "pop from empty buffer")
   `BDRB_ASSERT_SAME(a_ins_room, ctrl.insert, count_ff < CNT_W'(DEPTH), "insert into full buffer")
   `BDRB_ASSERT_NEXT(a_ins_count, ctrl.insert,
                     count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "insert lost count")
   `BDRB_ASSERT_SAME(a_idle_no_force, state_ff == S_IDLE, !force_pend_ff,
                     "forced item left undelivered")

endmodule

### verif/bounded_disorder_reorder_buffer_tb.sv
`timescale 1ns / 1ps

module bounded_disorder_reorder_buffer_tb;
   import bdrb_pkg::*;

   localparam int          LIMIT    = 400000;
   localparam int          HOLD_LEN = 400;
   localparam int          SETTLE   = 12;
   localparam [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
   localparam [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

   typedef struct {
      logic                kind;
      logic [CONTIG_W-1:0] contig;
      logic [POS_W-1:0]    position;
      logic [CARGO_W-1:0]  cargo;
   } feed_type;

   typedef struct {
      entry_type ent;
      logic      forced;
      logic      last;
   } release_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [SPAN_W-1:0]   csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   bounded_disorder_reorder_buffer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sorted copy of the held entries and the releases still owed
   entry_type   held[$];
   release_type owed[$];
   feed_type    pend[$];
   feed_type    offered;
   logic [SPAN_W-1:0] span_reg = '0;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   bit   tx_quiet = 1'b0;
   bit   rx_quiet = 1'b0;
   bit   hold_ask = 1'b0;
   bit   hold_taken = 1'b0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   hold_left = 0;
   int   cycles = 0;
   int   failures = 0;
   int   n_items = 0;
   int   n_flush = 0;
   int   n_results = 0;
   int   n_forced = 0;

   logic [CONTIG_W-1:0] cur_contig = '0;
   longint              cur_pos = 0;

   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void add_pend(feed_type it);
      pend.insert(pend.size(), it);
   endfunction

   function automatic void pop_oldest(bit frc);
      release_type r;
      r.ent    = held[0];
      r.forced = frc;
      r.last   = 1'b0;
      owed.insert(owed.size(), r);
      held.delete(0);
   endfunction

   function automatic void predict_releases(feed_type it);
      int        n;
      int        at;
      int        b;
      entry_type e;
      logic      far;
      n = 0;
      if (it.kind == KIND_FLUSH) begin
         while (held.size() > 0 && n < DEPTH) begin
            pop_oldest(1'b0);
            n++;
         end
      end else begin
         e.contig   = it.contig;
         e.position = it.position;
         e.cargo    = it.cargo;
         if (held.size() >= DEPTH) begin
            pop_oldest(1'b1);
            n++;
         end
         at = 0;
         while (at < held.size() && held[at] <= e) at++;
         held.insert(at, e);
         while (held.size() > 1 && n < DEPTH) begin
            b = held.size() - 1;
            if (held[b].contig != held[0].contig)
               far = 1'b1;
            else
               far = ({1'b0, held[b].position} - {1'b0, held[0].position}) > span_reg;
            if (!far) break;
            pop_oldest(1'b0);
            n++;
         end
      end
      if (n > 0) owed[owed.size()-1].last = 1'b1;
   endfunction

   function automatic void note_mismatch(string fname, longint expv, longint actv);
      $error("%s mismatch: expected %0d, actual %0d", fname, expv, actv);
      failures++;
   endfunction

   // driver
   always @(negedge clock) begin
      feed_type nxt;
      if (!(req_tvalid && !req_fire)) begin
         if (req_fire) send_gap = draw_gap(tx_quiet);
         if (send_gap == 0 && pend.size() != 0) begin
            nxt = pend[0];
            pend.delete(0);
            offered = nxt;
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.kind;
            req_tdata  <= {{(DATA_W-ENTRY_W){1'b0}}, nxt.cargo, nxt.position, nxt.contig};
         end else begin
            if (send_gap != 0) send_gap--;
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_ask && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_LEN;
      end
      if (rsp_fire) recv_gap = draw_gap(rx_quiet);
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      release_type want;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire) begin
         n_items++;
         if (offered.kind == KIND_FLUSH) n_flush++;
         predict_releases(offered);
      end
      if (rsp_fire) begin
         n_results++;
         if (owed.size() == 0) begin
            $error("result with no expected release pending");
            failures++;
         end else begin
            want = owed[0];
            owed.delete(0);
            if (want.forced) n_forced++;
            if (rsp_tdata[CONTIG_W-1:0] !== want.ent.contig)
               note_mismatch("out_contig", want.ent.contig, rsp_tdata[CONTIG_W-1:0]);
            if (rsp_tdata[CONTIG_W +: POS_W] !== want.ent.position)
               note_mismatch("out_position", want.ent.position, rsp_tdata[CONTIG_W +: POS_W]);
            if (rsp_tdata[CONTIG_W+POS_W +: CARGO_W] !== want.ent.cargo)
               note_mismatch("out_cargo", want.ent.cargo, rsp_tdata[CONTIG_W+POS_W +: CARGO_W]);
            if (rsp_tuser !== want.forced)
               note_mismatch("forced", want.forced, rsp_tuser);
            if (rsp_tlast !== want.last)
               note_mismatch("last", want.last, rsp_tlast);
         end
      end
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("bounded_disorder_reorder_buffer verification failed");
         $finish;
      end
   end

   function automatic feed_type mk(logic k, int c, longint p, int g);
      feed_type it;
      it.kind     = k;
      it.contig   = c[CONTIG_W-1:0];
      it.position = p[POS_W-1:0];
      it.cargo    = g[CARGO_W-1:0];
      return it;
   endfunction

   // nearly sorted stream with occasional contig hops, flushes and junk items
   task automatic queue_stream(int count, int step_max, int jitter, int hop_pct, int noise_pct);
      feed_type it;
      int       roll;
      longint   p;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            it = mk(KIND_FLUSH, $urandom, {$urandom, $urandom}, $urandom);
         end else if (roll < 5 + noise_pct) begin
            it = mk(KIND_INSERT, $urandom, {$urandom, $urandom}, $urandom);
         end else begin
            if ($urandom_range(0, 99) < hop_pct) begin
               cur_contig = cur_contig + CONTIG_W'($urandom_range(1, 2));
               cur_pos    = longint'($urandom_range(0, 1000));
            end else if ($urandom_range(0, 99) == 0) begin
               cur_pos = longint'($urandom_range(0, 32'h7FFF_0000));
            end
            cur_pos = cur_pos + longint'($urandom_range(0, step_max));
            if (cur_pos > longint'(POS_MAX)) cur_pos = longint'(POS_MAX);
            p = cur_pos - longint'($urandom_range(0, jitter));
            if (p < 0) p = 0;
            it = mk(KIND_INSERT, cur_contig, p,
                    $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
         end
         add_pend(it);
      end
   endtask

   task automatic wait_idle();
      while (pend.size() != 0 || req_tvalid || owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_span(logic [SPAN_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      span_reg  = v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset span of zero
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      add_pend(mk(KIND_INSERT, 0, 0, 0));
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      add_pend(mk(KIND_INSERT, 5, 100, 7));
      add_pend(mk(KIND_INSERT, 5, 100, 7));
      add_pend(mk(KIND_INSERT, 5, 100, 3));
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      add_pend(mk(KIND_INSERT, 65535, POS_MAX, 255));
      add_pend(mk(KIND_INSERT, 0, 0, 0));
      add_pend(mk(KIND_INSERT, 65535, POS_MAX - 1, 128));
      add_pend(mk(KIND_INSERT, 3, 5, 1));
      add_pend(mk(KIND_FLUSH, 65535, POS_MAX, 255));
      add_pend(mk(KIND_INSERT, 7, 10, 0));
      add_pend(mk(KIND_INSERT, 7, 11, 0));
      add_pend(mk(KIND_INSERT, 7, 11, 0));
      add_pend(mk(KIND_INSERT, 7, 9, 200));
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      wait_idle();

      // widest span, one contig: items are held until the buffer fills and forces the head out or a flush comes
      write_span(SPAN_MAX);
      queue_stream(50, 64, 16, 0, 0);
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      wait_idle();

      // narrow span while the receiver holds off
      write_span(1);
      hold_ask = 1'b1;
      queue_stream(80, 4, 3, 5, 5);
      wait_idle();

      write_span(SPAN_W'($urandom_range(16, 4096)));
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      queue_stream(80, 200, 300, 4, 5);
      wait_idle();

      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      write_span(0);
      queue_stream(60, 3, 2, 3, 10);
      wait_idle();

      write_span(SPAN_W'($urandom_range(0, SPAN_MAX)));
      queue_stream(70, 20000, 40000, 5, 5);
      add_pend(mk(KIND_FLUSH, 0, 0, 0));
      wait_idle();

      $display("%0d items (%0d flushes) checked against %0d releases, %0d forced",
               n_items, n_flush, n_results, n_forced);
      $display("span settings: reset zero, max, one, mid, zero, random; %0d cycles", cycles);
      if (failures == 0)
         $display("bounded_disorder_reorder_buffer verification clean");
      else
         $display("bounded_disorder_reorder_buffer verification failed");
      $finish;
   end

endmodule
